### design/hvd_pkg.sv
// ---------------------------------------------------------------------------
// hvd_pkg
// Shared types and constants for the scaled HMM Viterbi decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package hvd_pkg;

   localparam int PROB_W    = 32;          // Q0.32 probabilities and scores
   localparam int DIV_STEPS = PROB_W + 1;  // quotient bits, one per cycle
   localparam int SCALE_W   = 36;          // Q4.32 scale on the result port

   localparam logic [2:0] CMD_LOAD_TRANS = 3'd0;
   localparam logic [2:0] CMD_LOAD_EMIS  = 3'd1;
   localparam logic [2:0] CMD_LOAD_PRIOR = 3'd2;
   localparam logic [2:0] CMD_PHOTON     = 3'd3;
   localparam logic [2:0] CMD_READ_PATH  = 3'd4;

   localparam logic [1:0] KIND_ACK   = 2'd0;
   localparam logic [1:0] KIND_SCALE = 2'd1;
   localparam logic [1:0] KIND_PATH  = 2'd2;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PATH_RD,
      ST_PATH_WAIT,
      ST_PH_START,
      ST_INIT_RD,
      ST_INIT_MUL,
      ST_INIT_ACC,
      ST_REC_RD,
      ST_REC_MUL,
      ST_REC_CMP,
      ST_REC_EMIS_RD,
      ST_REC_EMIS_MUL,
      ST_REC_ACC,
      ST_NORM,
      ST_NORM_START,
      ST_NORM_WAIT,
      ST_PH_DONE,
      ST_TERM,
      ST_TERM_WR,
      ST_BT_RD,
      ST_BT_WAIT,
      ST_RESP
   } hvd_state_type;

endpackage

`default_nettype wire

### design/hvd_ram.sv
// ---------------------------------------------------------------------------
// hvd_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module hvd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/hvd_div.sv
// ---------------------------------------------------------------------------
// hvd_div
// Radix-2 restoring divider for score normalization: (numer << 32) / denom,
// saturated to all ones. Assumes numer <= denom, denom nonzero.
// ---------------------------------------------------------------------------
`default_nettype none

module hvd_div #(
   parameter int SUM_W = 35
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [hvd_pkg::PROB_W-1:0] numer,
   input  wire logic [SUM_W-1:0]           denom,
   output logic                            done,
   output logic      [hvd_pkg::PROB_W-1:0] quot
);

   import hvd_pkg::*;

   localparam int CNT_W = $clog2(DIV_STEPS + 1);

   logic [SUM_W-1:0]     rem_ff, rem_in;
   logic [DIV_STEPS-1:0] sh_ff, sh_in;
   logic [DIV_STEPS-1:0] q_ff, q_in;
   logic [CNT_W-1:0]     cnt_ff, cnt_in;
   logic                 done_ff, done_in;
   logic [SUM_W:0]       trial;

   assign trial = {rem_ff, sh_ff[DIV_STEPS-1]};

   always_comb begin
      rem_in  = rem_ff;
      sh_in   = sh_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (start) begin
         // quotient fits in DIV_STEPS bits, so skip the leading dividend bits
         rem_in = SUM_W'(numer >> 1);
         sh_in  = {numer[0], {PROB_W{1'b0}}};
         q_in   = '0;
         cnt_in = CNT_W'(DIV_STEPS);
      end else if (cnt_ff != '0) begin
         if (trial >= {1'b0, denom}) begin
            rem_in = SUM_W'(trial - {1'b0, denom});
            q_in   = {q_ff[DIV_STEPS-2:0], 1'b1};
         end else begin
            rem_in = SUM_W'(trial);
            q_in   = {q_ff[DIV_STEPS-2:0], 1'b0};
         end
         sh_in   = {sh_ff[DIV_STEPS-2:0], 1'b0};
         cnt_in  = cnt_ff - 1'b1;
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      sh_ff  <= sh_in;
      q_ff   <= q_in;
   end

   assign done = done_ff;
   assign quot = q_ff[PROB_W] ? {PROB_W{1'b1}} : q_ff[PROB_W-1:0];

endmodule

`default_nettype wire

### design/hmm_viterbi_decoder.sv
// A photon's run time is set by the single shared multiplier and the
//   one-bit-per-cycle divider; a last photon adds a backtrace to the burst start.
// Throughput: one item at a time; a new item is taken while a result waits.
// Reset: synchronous, clears control, scores, photon position; tables undefined.
// ---------------------------------------------------------------------------
// hmm_viterbi_decoder
// Scaled Viterbi decoder for an HMM with a per-photon transition matrix.
// ---------------------------------------------------------------------------
`default_nettype none

module hmm_viterbi_decoder #(
   parameter int MAX_STATES    = 8,
   parameter int MAX_PHOTONS   = 1024,
   parameter int MAX_POWERS    = 32,
   parameter int MAX_DETECTORS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data,
   // request channel
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [2:0]  req_cmd,
   input  wire logic [4:0]  req_power_index,
   input  wire logic [2:0]  req_from_state,
   input  wire logic [2:0]  req_to_state,
   input  wire logic [1:0]  req_detector,
   input  wire logic [31:0] req_prob_value,
   input  wire logic        req_last_photon,
   input  wire logic [9:0]  req_read_position,
   // response channel
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [35:0]      rsp_scale_value,
   output logic [2:0]       rsp_path_state,
   output logic             rsp_zero_sum,
   output logic             rsp_overflow
);

   import hvd_pkg::*;

   localparam int SI_W     = $clog2(MAX_STATES);       // state index
   localparam int SC_W     = $clog2(MAX_STATES + 1);   // state count
   localparam int PA_W     = $clog2(MAX_PHOTONS);      // path address
   localparam int PP_W     = $clog2(MAX_PHOTONS + 1);  // photon position
   localparam int TR_DEPTH = MAX_POWERS * MAX_STATES * MAX_STATES;
   localparam int TR_AW    = (TR_DEPTH > 1) ? $clog2(TR_DEPTH) : 1;
   localparam int EM_DEPTH = MAX_DETECTORS * MAX_STATES;
   localparam int EM_AW    = (EM_DEPTH > 1) ? $clog2(EM_DEPTH) : 1;
   localparam int BP_DEPTH = MAX_PHOTONS * MAX_STATES;
   localparam int BP_AW    = $clog2(BP_DEPTH);
   localparam int SUM_W    = PROB_W + $clog2(MAX_STATES);

   // ---------------- registers ----------------
   hvd_state_type     state_ff, state_in;

   logic [2:0]        cmd_ff, cmd_in;
   logic [4:0]        pw_ff, pw_in;
   logic [2:0]        fr_ff, fr_in;
   logic [2:0]        to_ff, to_in;
   logic [1:0]        det_ff, det_in;
   logic [PROB_W-1:0] prob_ff, prob_in;
   logic              last_ff, last_in;
   logic [9:0]        rpos_ff, rpos_in;

   logic [3:0]        num_ff, num_in;       // num_states register
   logic [SC_W-1:0]   bstates_ff, bstates_in; // state count latched per burst
   logic              bov_ff, bov_in;       // sticky burst overflow
   logic [PP_W-1:0]   pos_ff, pos_in;       // photon position

   logic [SC_W-1:0]   i_ff, i_in;
   logic [SC_W-1:0]   k_ff, k_in;
   logic [2*PROB_W-1:0] best_ff, best_in;
   logic [SI_W-1:0]   arg_ff, arg_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic              zs_ff, zs_in;
   logic [2*PROB_W-1:0] prod_ff, prod_in;
   logic [PROB_W-1:0] score_ff [MAX_STATES];
   logic [PROB_W-1:0] score_in [MAX_STATES];
   logic [PROB_W-1:0] nxt_ff [MAX_STATES];
   logic [PROB_W-1:0] nxt_in [MAX_STATES];
   logic [PA_W-1:0]   t_ff, t_in;
   logic [SI_W-1:0]   cur_ff, cur_in;
   logic [SI_W-1:0]   pst_ff, pst_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [1:0]        rsp_kind_ff, rsp_kind_in;
   logic [SCALE_W-1:0] rsp_scale_ff, rsp_scale_in;
   logic [2:0]        rsp_pst_ff, rsp_pst_in;
   logic              rsp_zs_ff, rsp_zs_in;
   logic              rsp_ov_ff, rsp_ov_in;

   // ---------------- memory ports ----------------
   logic              tr_we;
   logic [TR_AW-1:0]  tr_waddr, tr_raddr;
   logic [PROB_W-1:0] tr_rd;
   logic              em_we;
   logic [EM_AW-1:0]  em_waddr, em_raddr;
   logic [PROB_W-1:0] em_rd;
   logic              pr_we;
   logic [SI_W-1:0]   pr_waddr, pr_raddr;
   logic [PROB_W-1:0] pr_rd;
   logic              bp_we;
   logic [BP_AW-1:0]  bp_waddr, bp_raddr;
   logic [SI_W-1:0]   bp_wdata, bp_rd;
   logic              pa_we;
   logic [PA_W-1:0]   pa_waddr, pa_raddr;
   logic [SI_W-1:0]   pa_wdata, pa_rd;

   // ---------------- datapath helpers ----------------
   logic [PROB_W-1:0] mul_a, mul_b;
   logic [SI_W-1:0]   sel_idx;
   logic [PROB_W-1:0] score_sel;
   logic [PROB_W-1:0] emis_v, trans_v;
   logic              det_ok, pw_ok;
   logic [SC_W-1:0]   eff_states;
   logic              div_start, div_done;
   logic [PROB_W-1:0] div_quot;
   logic [PP_W-1:0]   tail;

   // Tables indexed past their built size read as zero probability.
   assign det_ok  = 32'(det_ff) < 32'(MAX_DETECTORS);
   assign pw_ok   = 32'(pw_ff) < 32'(MAX_POWERS);
   assign emis_v  = det_ok ? em_rd : '0;
   assign trans_v = pw_ok ? tr_rd : '0;

   // One read index into the score registers: predecessor k while scoring
   // candidates, the current state i everywhere else.
   assign sel_idx   = (state_ff == ST_REC_MUL) ? k_ff[SI_W-1:0] : i_ff[SI_W-1:0];
   assign score_sel = score_ff[sel_idx];

   // Effective state count: zero counts as one, clip at the built size.
   always_comb begin
      if (num_ff == 4'd0) begin
         eff_states = SC_W'(1);
      end else if (32'(num_ff) > 32'(MAX_STATES)) begin
         eff_states = SC_W'(MAX_STATES);
      end else begin
         eff_states = SC_W'(num_ff);
      end
   end

   assign prod_in = 64'(mul_a) * 64'(mul_b);
   assign tail    = (pos_ff == '0) ? '0 : pos_ff - 1'b1;

   // ---------------- sequencer ----------------
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      pw_in        = pw_ff;
      fr_in        = fr_ff;
      to_in        = to_ff;
      det_in       = det_ff;
      prob_in      = prob_ff;
      last_in      = last_ff;
      rpos_in      = rpos_ff;
      num_in       = num_ff;
      bstates_in   = bstates_ff;
      bov_in       = bov_ff;
      pos_in       = pos_ff;
      i_in         = i_ff;
      k_in         = k_ff;
      best_in      = best_ff;
      arg_in       = arg_ff;
      sum_in       = sum_ff;
      zs_in        = zs_ff;
      t_in         = t_ff;
      cur_in       = cur_ff;
      pst_in       = pst_ff;
      score_in     = score_ff;
      nxt_in       = nxt_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_scale_in = rsp_scale_ff;
      rsp_pst_in   = rsp_pst_ff;
      rsp_zs_in    = rsp_zs_ff;
      rsp_ov_in    = rsp_ov_ff;

      mul_a     = '0;
      mul_b     = '0;
      div_start = 1'b0;

      tr_we    = 1'b0;
      tr_waddr = TR_AW'((32'(pw_ff) * 32'(MAX_STATES) + 32'(fr_ff)) * 32'(MAX_STATES)
                        + 32'(to_ff));
      tr_raddr = TR_AW'((32'(pw_ff) * 32'(MAX_STATES) + 32'(k_ff)) * 32'(MAX_STATES)
                        + 32'(i_ff));
      em_we    = 1'b0;
      em_waddr = EM_AW'(32'(det_ff) * 32'(MAX_STATES) + 32'(to_ff));
      em_raddr = EM_AW'(32'(det_ff) * 32'(MAX_STATES) + 32'(i_ff));
      pr_we    = 1'b0;
      pr_waddr = SI_W'(to_ff);
      pr_raddr = i_ff[SI_W-1:0];
      bp_we    = 1'b0;
      bp_waddr = BP_AW'(32'(pos_ff) * 32'(MAX_STATES) + 32'(i_ff));
      bp_wdata = arg_ff;
      bp_raddr = BP_AW'(32'(t_ff) * 32'(MAX_STATES) + 32'(cur_ff));
      pa_we    = 1'b0;
      pa_waddr = t_ff;
      pa_wdata = arg_ff;
      pa_raddr = PA_W'(rpos_ff);

      // Config writes land whenever offered.
      if (csr_wr_en) begin
         num_in = csr_wr_data;
      end

      // Drop the waiting result beat once the far side takes it.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_cmd;
               pw_in   = req_power_index;
               fr_in   = req_from_state;
               to_in   = req_to_state;
               det_in  = req_detector;
               prob_in = req_prob_value;
               last_in = req_last_photon;
               rpos_in = req_read_position;
               case (req_cmd)
                  CMD_LOAD_TRANS, CMD_LOAD_EMIS, CMD_LOAD_PRIOR: state_in = ST_LOAD;
                  CMD_PHOTON:    state_in = ST_PH_START;
                  CMD_READ_PATH: state_in = ST_PATH_RD;
                  default:       state_in = ST_RESP;
               endcase
            end
         end

         ST_LOAD: begin
            // Out-of-range loads are acknowledged but not stored.
            case (cmd_ff)
               CMD_LOAD_TRANS: tr_we = pw_ok && (32'(fr_ff) < 32'(MAX_STATES))
                                     && (32'(to_ff) < 32'(MAX_STATES));
               CMD_LOAD_EMIS:  em_we = det_ok && (32'(to_ff) < 32'(MAX_STATES));
               CMD_LOAD_PRIOR: pr_we = 32'(to_ff) < 32'(MAX_STATES);
               default: ;
            endcase
            state_in = ST_RESP;
         end

         ST_PATH_RD: begin
            state_in = ST_PATH_WAIT;
         end

         ST_PATH_WAIT: begin
            pst_in   = (32'(rpos_ff) < 32'(MAX_PHOTONS)) ? pa_rd : '0;
            state_in = ST_RESP;
         end

         ST_PH_START: begin
            sum_in  = '0;
            zs_in   = 1'b0;
            i_in    = '0;
            k_in    = '0;
            best_in = '0;
            arg_in  = '0;
            if (pos_ff == '0) begin
               bstates_in = eff_states;
               bov_in     = 1'b0;
            end
            if (32'(pos_ff) >= 32'(MAX_PHOTONS)) begin
               // Burst too long: drop the photon, keep the scores.
               bov_in   = 1'b1;
               state_in = last_ff ? ST_TERM : ST_RESP;
            end else if (pos_ff == '0) begin
               state_in = ST_INIT_RD;
            end else begin
               state_in = ST_REC_RD;
            end
         end

         // First photon: score = prior * emission.
         ST_INIT_RD: begin
            state_in = ST_INIT_MUL;
         end

         ST_INIT_MUL: begin
            mul_a    = pr_rd;
            mul_b    = emis_v;
            state_in = ST_INIT_ACC;
         end

         ST_INIT_ACC: begin
            score_in[i_ff[SI_W-1:0]] = prod_ff[2*PROB_W-1:PROB_W];
            sum_in = sum_ff + SUM_W'(prod_ff[2*PROB_W-1:PROB_W]);
            if (SC_W'(i_ff + 1'b1) == bstates_ff) begin
               i_in     = '0;
               state_in = ST_NORM;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_INIT_RD;
            end
         end

         // Later photons: best predecessor per state, one candidate at a time.
         ST_REC_RD: begin
            state_in = ST_REC_MUL;
         end

         ST_REC_MUL: begin
            mul_a    = trans_v;
            mul_b    = score_sel;
            state_in = ST_REC_CMP;
         end

         ST_REC_CMP: begin
            // Strict compare keeps the lowest state on ties.
            if (prod_ff > best_ff) begin
               best_in = prod_ff;
               arg_in  = k_ff[SI_W-1:0];
            end
            if (SC_W'(k_ff + 1'b1) == bstates_ff) begin
               state_in = ST_REC_EMIS_RD;
            end else begin
               k_in     = k_ff + 1'b1;
               state_in = ST_REC_RD;
            end
         end

         ST_REC_EMIS_RD: begin
            bp_we    = 1'b1;
            state_in = ST_REC_EMIS_MUL;
         end

         ST_REC_EMIS_MUL: begin
            mul_a    = best_ff[2*PROB_W-1:PROB_W];
            mul_b    = emis_v;
            state_in = ST_REC_ACC;
         end

         ST_REC_ACC: begin
            nxt_in[i_ff[SI_W-1:0]] = prod_ff[2*PROB_W-1:PROB_W];
            sum_in  = sum_ff + SUM_W'(prod_ff[2*PROB_W-1:PROB_W]);
            k_in    = '0;
            best_in = '0;
            arg_in  = '0;
            if (SC_W'(i_ff + 1'b1) == bstates_ff) begin
               // Commit the new column only after every state has used the old one.
               for (int j = 0; j < MAX_STATES; j++) begin
                  if (32'(j) < 32'(bstates_ff)) begin
                     score_in[j] = nxt_in[j];
                  end
               end
               i_in     = '0;
               state_in = ST_NORM;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = ST_REC_RD;
            end
         end

         ST_NORM: begin
            if (sum_ff == '0) begin
               zs_in    = 1'b1;
               state_in = ST_PH_DONE;
            end else begin
               state_in = ST_NORM_START;
            end
         end

         ST_NORM_START: begin
            div_start = 1'b1;
            state_in  = ST_NORM_WAIT;
         end

         ST_NORM_WAIT: begin
            if (div_done) begin
               score_in[i_ff[SI_W-1:0]] = div_quot;
               if (SC_W'(i_ff + 1'b1) == bstates_ff) begin
                  state_in = ST_PH_DONE;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_NORM_START;
               end
            end
         end

         ST_PH_DONE: begin
            pos_in  = pos_ff + 1'b1;
            i_in    = '0;
            best_in = '0;
            arg_in  = '0;
            state_in = last_ff ? ST_TERM : ST_RESP;
         end

         // Termination: pick the best final state, all-zero picks state 0.
         ST_TERM: begin
            if (i_ff == bstates_ff) begin
               state_in = ST_TERM_WR;
            end else begin
               if ((2*PROB_W)'(score_sel) > best_ff) begin
                  best_in = (2*PROB_W)'(score_sel);
                  arg_in  = i_ff[SI_W-1:0];
               end
               i_in = i_ff + 1'b1;
            end
         end

         ST_TERM_WR: begin
            pa_we    = 1'b1;
            pa_waddr = PA_W'(tail);
            cur_in   = arg_ff;
            t_in     = PA_W'(tail);
            pos_in   = '0;
            state_in = (tail == '0) ? ST_RESP : ST_BT_RD;
         end

         // Backtrace: follow stored pointers toward the burst start.
         ST_BT_RD: begin
            state_in = ST_BT_WAIT;
         end

         ST_BT_WAIT: begin
            pa_we    = 1'b1;
            pa_waddr = t_ff - 1'b1;
            pa_wdata = bp_rd;
            cur_in   = bp_rd;
            t_in     = t_ff - 1'b1;
            state_in = (t_ff == PA_W'(1)) ? ST_RESP : ST_BT_RD;
         end

         ST_RESP: begin
            // Load the output register once it is free or being emptied.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_scale_in = '0;
               rsp_pst_in   = '0;
               rsp_zs_in    = 1'b0;
               rsp_ov_in    = 1'b0;
               case (cmd_ff)
                  CMD_PHOTON: begin
                     rsp_kind_in  = KIND_SCALE;
                     rsp_scale_in = SCALE_W'(sum_ff);
                     rsp_zs_in    = zs_ff;
                     rsp_ov_in    = bov_ff;
                  end
                  CMD_READ_PATH: begin
                     rsp_kind_in = KIND_PATH;
                     rsp_pst_in  = 3'(pst_ff);
                  end
                  default: rsp_kind_in = KIND_ACK;
               endcase
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_ff       <= 4'd2;
         bstates_ff   <= SC_W'(2);
         bov_ff       <= 1'b0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < MAX_STATES; j++) begin
            score_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         num_ff       <= num_in;
         bstates_ff   <= bstates_in;
         bov_ff       <= bov_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         score_ff     <= score_in;
      end
      cmd_ff       <= cmd_in;
      pw_ff        <= pw_in;
      fr_ff        <= fr_in;
      to_ff        <= to_in;
      det_ff       <= det_in;
      prob_ff      <= prob_in;
      last_ff      <= last_in;
      rpos_ff      <= rpos_in;
      i_ff         <= i_in;
      k_ff         <= k_in;
      best_ff      <= best_in;
      arg_ff       <= arg_in;
      sum_ff       <= sum_in;
      zs_ff        <= zs_in;
      prod_ff      <= prod_in;
      nxt_ff       <= nxt_in;
      t_ff         <= t_in;
      cur_ff       <= cur_in;
      pst_ff       <= pst_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_scale_ff <= rsp_scale_in;
      rsp_pst_ff   <= rsp_pst_in;
      rsp_zs_ff    <= rsp_zs_in;
      rsp_ov_ff    <= rsp_ov_in;
   end

   // ---------------- memories and divider ----------------
   hvd_ram #(.WIDTH(PROB_W), .DEPTH(TR_DEPTH)) u_trans (
      .clock(clock), .wr_en(tr_we), .wr_addr(tr_waddr), .wr_data(prob_ff),
      .rd_addr(tr_raddr), .rd_data(tr_rd)
   );

   hvd_ram #(.WIDTH(PROB_W), .DEPTH(EM_DEPTH)) u_emis (
      .clock(clock), .wr_en(em_we), .wr_addr(em_waddr), .wr_data(prob_ff),
      .rd_addr(em_raddr), .rd_data(em_rd)
   );

   hvd_ram #(.WIDTH(PROB_W), .DEPTH(MAX_STATES)) u_prior (
      .clock(clock), .wr_en(pr_we), .wr_addr(pr_waddr), .wr_data(prob_ff),
      .rd_addr(pr_raddr), .rd_data(pr_rd)
   );

   hvd_ram #(.WIDTH(SI_W), .DEPTH(BP_DEPTH)) u_bptr (
      .clock(clock), .wr_en(bp_we), .wr_addr(bp_waddr), .wr_data(bp_wdata),
      .rd_addr(bp_raddr), .rd_data(bp_rd)
   );

   hvd_ram #(.WIDTH(SI_W), .DEPTH(MAX_PHOTONS)) u_path (
      .clock(clock), .wr_en(pa_we), .wr_addr(pa_waddr), .wr_data(pa_wdata),
      .rd_addr(pa_raddr), .rd_data(pa_rd)
   );

   hvd_div #(.SUM_W(SUM_W)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .numer(score_sel),
      .denom(sum_ff), .done(div_done), .quot(div_quot)
   );

   // ---------------- ports ----------------
   assign req_stall       = (state_ff != ST_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result_kind = rsp_kind_ff;
   assign rsp_scale_value = rsp_scale_ff;
   assign rsp_path_state  = rsp_pst_ff;
   assign rsp_zero_sum    = rsp_zs_ff;
   assign rsp_overflow    = rsp_ov_ff;

endmodule

`default_nettype wire
